### sv/ultrasonic_approach_detector_top_macros.svh
// Assertion macros used by the checker in uad_checker.sv.
`ifndef ULTRASONIC_APPROACH_DETECTOR_TOP_MACROS_SVH
`define ULTRASONIC_APPROACH_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define UAD_ASSERT_NOW(label, clk, dis, a, b) \
  label: assert property (@(posedge clk) disable iff (dis) (a) |-> (b)) \
    else $error("uad assertion failed");

// Next-cycle implication, disabled while dis is high.
`define UAD_ASSERT_NEXT(label, clk, dis, a, b) \
  label: assert property (@(posedge clk) disable iff (dis) (a) |=> (b)) \
    else $error("uad assertion failed");

`endif

### sv/uad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package uad_pkg;

  localparam int HISTORY_DEPTH_DEF = 10;

  localparam int ECHO_W = 16;
  localparam int DIST_W = 11;
  localparam int HIST_W = 7;
  localparam int FALL_W = 4;
  localparam int THR_W = 4;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FALLS = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_THR = 4'd3;

  localparam logic [HIST_W-1:0] MAX_DIST_RST = 7'd100;
  localparam logic [HIST_W-1:0] MIN_DIST_RST = 7'd10;
  localparam logic [FALL_W-1:0] MIN_FALLS_RST = 4'd5;
  localparam logic [THR_W-1:0] FALL_THR_RST = 4'd1;

  // Division by 58 as a multiply by ceil(2^21 / 58) and a shift; exact for 16-bit widths.
  localparam int RECIP_SHIFT = 21;
  localparam int PROD_W = 32;
  localparam logic [ECHO_W-1:0] RECIP_MUL = 16'd36158;

endpackage

`default_nettype wire

### sv/uad_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface uad_cfg_if import uad_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface uad_echo_if import uad_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ECHO_W-1:0] echo_width_us;
  modport source (output valid, echo_width_us, input ready);
  modport sink (input valid, echo_width_us, output ready);
endinterface

interface uad_result_if import uad_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance_cm;
  logic              sample_accepted;
  logic [FALL_W-1:0] fall_count;
  logic              wall_approaching;
  modport source (output valid, distance_cm, sample_accepted, fall_count, wall_approaching,
                  input ready);
  modport sink (input valid, distance_cm, sample_accepted, fall_count, wall_approaching,
                output ready);
endinterface

`default_nettype wire

### sv/uad_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module uad_cell import uad_pkg::*; #(
  parameter int CNT_W = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              shift,
  input  wire logic [HIST_W-1:0] shift_in,
  input  wire logic [HIST_W-1:0] prev_val,
  input  wire logic [CNT_W-1:0]  cnt_in,
  output logic      [HIST_W-1:0] val,
  output logic      [CNT_W-1:0]  cnt
);

  always_ff @(posedge clk) begin
    if (rst) begin
      val <= '0;
    end else if (shift) begin
      val <= shift_in;
    end
  end

  // The running fall count ripples one cell further each cycle.
  always_ff @(posedge clk) begin
    cnt <= cnt_in + CNT_W'(val < prev_val);
  end

endmodule

`default_nettype wire

### sv/uad_chain.sv
`timescale 1ns / 1ps
`default_nettype none

module uad_chain import uad_pkg::*; #(
  parameter int DEPTH = HISTORY_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     shift,
  input  wire logic [HIST_W-1:0]        din,
  output logic      [HIST_W-1:0]        oldest,
  output logic      [HIST_W-1:0]        newest,
  output logic      [$clog2(DEPTH)-1:0] falls
);

  localparam int CNT_W = $clog2(DEPTH);

  logic [HIST_W-1:0] val [DEPTH];
  logic [CNT_W-1:0]  cnt [DEPTH];

  // Cell 0 holds the oldest distance and the last cell the newest.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [HIST_W-1:0] shift_in;
    logic [HIST_W-1:0] prev_val;
    logic [CNT_W-1:0]  cnt_in;

    if (k == DEPTH - 1) begin : g_head
      assign shift_in = din;
    end else begin : g_body
      assign shift_in = val[k+1];
    end

    if (k == 0) begin : g_first
      assign prev_val = val[0];
      assign cnt_in = '0;
    end else begin : g_rest
      assign prev_val = val[k-1];
      assign cnt_in = cnt[k-1];
    end

    uad_cell #(.CNT_W(CNT_W)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (shift),
      .shift_in (shift_in),
      .prev_val (prev_val),
      .cnt_in   (cnt_in),
      .val      (val[k]),
      .cnt      (cnt[k])
    );
  end

  assign oldest = val[0];
  assign newest = val[DEPTH-1];
  assign falls = cnt[DEPTH-1];

endmodule

`default_nettype wire

### sv/ultrasonic_approach_detector_top.sv
// Channel  Role     Payload
// cfg      sink     index, data
// echo     sink     echo_width_us
// result   source   distance_cm, sample_accepted, fall_count, wall_approaching
//
// A stored sample passes from transfer through the states GATE, SCAN and DONE to the result;
// a rejected sample skips SCAN. The scan length is set by the fall count rippling through
// the row of history cells, one cell per cycle.
// Reset clears the history to zeros and loads the register defaults.
// One finished result waits in the output register while the next echo is taken.
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_approach_detector_top import uad_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input wire logic     clk,
  input wire logic     rst,
  uad_cfg_if.sink      cfg,
  uad_echo_if.sink     echo,
  uad_result_if.source result
);

  localparam int CNT_W = $clog2(HISTORY_DEPTH);
  localparam int CXW = (CNT_W > FALL_W) ? CNT_W : FALL_W;
  localparam int SUM_W = 8 + $clog2(HISTORY_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_GATE = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]        state;
  logic [CNT_W-1:0]  scan_cnt;
  logic [PROD_W-1:0] prod;
  logic [DIST_W-1:0] distance;
  logic [DIST_W-1:0] dist_reg;
  logic              accepted;
  logic              reject;
  logic              shift;
  logic              load_out;

  logic [HIST_W-1:0] max_dist;
  logic [HIST_W-1:0] min_dist;
  logic [FALL_W-1:0] min_falls;
  logic [THR_W-1:0]  fall_thr;

  logic [HIST_W-1:0] oldest;
  logic [HIST_W-1:0] newest;
  logic [CNT_W-1:0]  falls;
  logic [CXW-1:0]    falls_x;
  logic [SUM_W-1:0]  limit;
  logic              wall;

  logic              out_valid;
  logic [DIST_W-1:0] out_dist;
  logic              out_acc;
  logic [FALL_W-1:0] out_falls;
  logic              out_wall;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_dist <= MAX_DIST_RST;
      min_dist <= MIN_DIST_RST;
      min_falls <= MIN_FALLS_RST;
      fall_thr <= FALL_THR_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_MAX_DIST:  max_dist <= cfg.data[HIST_W-1:0];
        REG_MIN_DIST:  min_dist <= cfg.data[HIST_W-1:0];
        REG_MIN_FALLS: min_falls <= cfg.data[FALL_W-1:0];
        REG_FALL_THR:  fall_thr <= cfg.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign echo.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (echo.valid && echo.ready) begin
      prod <= PROD_W'(echo.echo_width_us) * PROD_W'(RECIP_MUL);
    end
  end

  assign distance = prod[RECIP_SHIFT +: DIST_W];
  assign reject = (distance > DIST_W'(max_dist)) || (distance <= DIST_W'(min_dist));
  assign shift = (state == S_GATE) && !reject;

  always_ff @(posedge clk) begin
    if (state == S_GATE) begin
      dist_reg <= distance;
      accepted <= !reject;
    end
  end

  uad_chain #(.DEPTH(HISTORY_DEPTH)) u_chain (
    .clk    (clk),
    .rst    (rst),
    .shift  (shift),
    .din    (distance[HIST_W-1:0]),
    .oldest (oldest),
    .newest (newest),
    .falls  (falls)
  );

  assign load_out = (state == S_DONE) && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      scan_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (echo.valid) begin
            state <= S_GATE;
          end
        end
        S_GATE: begin
          scan_cnt <= CNT_W'(HISTORY_DEPTH - 1);
          state <= reject ? S_DONE : S_SCAN;
        end
        S_SCAN: begin
          if (scan_cnt == '0) begin
            state <= S_DONE;
          end else begin
            scan_cnt <= scan_cnt - 1'b1;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign falls_x = CXW'(falls);
  assign limit = SUM_W'(newest) + SUM_W'(fall_thr) * SUM_W'(HISTORY_DEPTH - 1);
  assign wall = accepted && (falls_x >= CXW'(min_falls))
      && (dist_reg < DIST_W'(max_dist)) && (SUM_W'(oldest) > limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_dist <= dist_reg;
      out_acc <= accepted;
      out_falls <= accepted ? falls_x[FALL_W-1:0] : '0;
      out_wall <= wall;
    end
  end

  assign result.valid = out_valid;
  assign result.distance_cm = out_dist;
  assign result.sample_accepted = out_acc;
  assign result.fall_count = out_falls;
  assign result.wall_approaching = out_wall;

endmodule

`default_nettype wire

### sv/uad_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "ultrasonic_approach_detector_top_macros.svh"

module uad_checker import uad_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              echo_valid,
  input wire logic              echo_ready,
  input wire logic              res_valid,
  input wire logic              res_ready,
  input wire logic [DIST_W-1:0] res_dist,
  input wire logic              res_acc,
  input wire logic [FALL_W-1:0] res_falls,
  input wire logic              res_wall
);

  // A stalled result keeps its valid and its payload.
  `UAD_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready,
      res_valid && $stable(res_dist) && $stable(res_acc) && $stable(res_falls)
      && $stable(res_wall))

  // No result is pending right after reset.
  `UAD_ASSERT_NEXT(a_rst_empty, clk, 1'b0, rst, !res_valid)

  // After an echo transfer the block works on it before taking another.
  `UAD_ASSERT_NEXT(a_one_item, clk, rst, echo_valid && echo_ready, !echo_ready)

  // A rejected sample reports no falls and no wall.
  `UAD_ASSERT_NOW(a_reject_clean, clk, rst, res_valid && !res_acc,
      res_falls == '0 && !res_wall)

endmodule

bind ultrasonic_approach_detector_top uad_checker u_uad_checker (
  .clk        (clk),
  .rst        (rst),
  .echo_valid (echo.valid),
  .echo_ready (echo.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_dist   (result.distance_cm),
  .res_acc    (result.sample_accepted),
  .res_falls  (result.fall_count),
  .res_wall   (result.wall_approaching)
);

`default_nettype wire

### sim/approach_checker.sv
`timescale 1ns / 1ps

module approach_checker import uad_pkg::*; (
  input logic   clk,
  input logic   rst,
  uad_cfg_if    cfg,
  uad_echo_if   echo,
  uad_result_if result,
  output int    mismatches,
  output int    outstanding
);

  localparam int DEPTH = HISTORY_DEPTH_DEF;
  localparam int ECHO_US_PER_CM = 58;

  typedef struct packed {
    logic [DIST_W-1:0] distance_cm;
    logic              accepted;
    logic [FALL_W-1:0] fall_count;
    logic              wall;
  } reading_t;

  logic [HIST_W-1:0] max_dist;
  logic [HIST_W-1:0] min_dist;
  logic [FALL_W-1:0] min_falls;
  logic [THR_W-1:0]  fall_thr;
  logic [HIST_W-1:0] ring [DEPTH];
  int                next_slot;
  reading_t          expected_readings[$];

  initial mismatches = 0;
  initial outstanding = 0;

  task automatic report(input string msg);
    $display("%0t ns: %s", $realtime, msg);
    mismatches++;
  endtask

  // Updates the ring as the block would and returns the reading it should produce.
  function automatic reading_t predict_reading(input logic [ECHO_W-1:0] width);
    reading_t r;
    int dist_cm, falls, a, b, oldest, newest, i;
    dist_cm = int'(width) / ECHO_US_PER_CM;
    r = '0;
    r.distance_cm = dist_cm[DIST_W-1:0];
    if (dist_cm > int'(max_dist) || dist_cm <= int'(min_dist)) begin
      return r;
    end
    ring[next_slot] = dist_cm[HIST_W-1:0];
    next_slot = (next_slot == DEPTH - 1) ? 0 : next_slot + 1;
    falls = 0;
    a = next_slot;
    oldest = int'(ring[a]);
    for (i = 0; i < DEPTH - 1; i++) begin
      b = (a == DEPTH - 1) ? 0 : a + 1;
      if (ring[b] < ring[a]) begin
        falls++;
      end
      a = b;
    end
    newest = int'(ring[a]);
    r.accepted = 1'b1;
    r.fall_count = falls[FALL_W-1:0];
    r.wall = (falls >= int'(min_falls)) && (dist_cm < int'(max_dist))
             && (oldest - newest > int'(fall_thr) * (DEPTH - 1));
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      max_dist = MAX_DIST_RST;
      min_dist = MIN_DIST_RST;
      min_falls = MIN_FALLS_RST;
      fall_thr = FALL_THR_RST;
      foreach (ring[k]) ring[k] = '0;
      next_slot = 0;
      expected_readings.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_MAX_DIST: max_dist = cfg.data[HIST_W-1:0];
          REG_MIN_DIST: min_dist = cfg.data[HIST_W-1:0];
          REG_MIN_FALLS: min_falls = cfg.data[FALL_W-1:0];
          REG_FALL_THR: fall_thr = cfg.data[THR_W-1:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (expected_readings.size() == 0) begin
          report($sformatf("result transfer with nothing pending, distance %0d",
                           result.distance_cm));
        end else begin
          want = expected_readings.pop_front();
          if (result.distance_cm !== want.distance_cm)
            report($sformatf("distance_cm got %0d, expected %0d",
                             result.distance_cm, want.distance_cm));
          if (result.sample_accepted !== want.accepted)
            report($sformatf("sample_accepted got %0b, expected %0b (distance %0d)",
                             result.sample_accepted, want.accepted, want.distance_cm));
          if (result.fall_count !== want.fall_count)
            report($sformatf("fall_count got %0d, expected %0d (distance %0d)",
                             result.fall_count, want.fall_count, want.distance_cm));
          if (result.wall_approaching !== want.wall)
            report($sformatf("wall_approaching got %0b, expected %0b (distance %0d)",
                             result.wall_approaching, want.wall, want.distance_cm));
        end
      end
      if (echo.valid && echo.ready) begin
        expected_readings.push_back(predict_reading(echo.echo_width_us));
      end
    end
    outstanding <= expected_readings.size();
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import uad_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatches;
  int   outstanding;
  int   idle_cycles = 0;
  int   hold_requests = 0;
  int   burst_left = 1;
  bit   gaps_on = 1'b1;

  uad_cfg_if    cfg();
  uad_echo_if   echo();
  uad_result_if result();

  always #4 clk = ~clk;

  ultrasonic_approach_detector_top dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .echo   (echo),
    .result (result)
  );

  approach_checker approach_chk (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .echo        (echo),
    .result      (result),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    if (rst || (echo.valid && echo.ready) || (cfg.valid && cfg.ready)
        || (result.valid && result.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: stall patterns change at random, plus long holds on request.
  initial begin
    int hold_left, hold_seen, pattern, span;
    hold_left = 0;
    hold_seen = 0;
    pattern = 0;
    span = 0;
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (span == 0) begin
        pattern = $urandom_range(0, 3);
        span = $urandom_range(20, 120);
      end
      span--;
      if (hold_left > 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else begin
        case (pattern)
          0: result.ready <= 1'b1;
          1: result.ready <= 1'($urandom);
          2: result.ready <= ($urandom_range(0, 3) != 0);
          default: result.ready <= (span % 5 == 0);
        endcase
      end
    end
  end

  task automatic send_echo(input logic [ECHO_W-1:0] width);
    int gap;
    echo.valid <= 1'b1;
    echo.echo_width_us <= width;
    @(posedge clk);
    while (!echo.ready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) begin
        gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        echo.valid <= 1'b0;
        echo.echo_width_us <= ECHO_W'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_distance(input int cm);
    send_echo(ECHO_W'(cm * 58 + $urandom_range(0, 57)));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  // Writes the registers once the block has drained, then mostly sends falling
  // distance runs inside the accepted window, mixed with arbitrary widths.
  task automatic run_phase(input int target, input int max_d, input int min_d,
                           input int falls, input int thr, input bit gaps, input bit hold);
    int sent, lo, hi, n, d, kind;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    write_reg(REG_MAX_DIST, {1'($urandom), 7'(max_d)});
    write_reg(REG_MIN_DIST, {1'($urandom), 7'(min_d)});
    write_reg(REG_MIN_FALLS, {4'($urandom), 4'(falls)});
    write_reg(REG_FALL_THR, {4'($urandom), 4'(thr)});
    write_reg(CFG_IDX_W'($urandom_range(4, 15)), CFG_DATA_W'($urandom));
    cfg.valid <= 1'b0;
    gaps_on = gaps;
    if (hold) begin
      hold_requests++;
    end
    lo = min_d + 1;
    hi = max_d;
    sent = 0;
    while (sent < target) begin
      kind = $urandom_range(0, 9);
      if (kind < 7 && lo <= hi) begin
        n = $urandom_range(3, 14);
        d = $urandom_range((lo + hi) / 2, hi);
        repeat (n) begin
          send_distance(d);
          sent++;
          if ($urandom_range(0, 9) == 0) begin
            d += $urandom_range(1, 4);
          end else begin
            d -= $urandom_range(0, 2 * thr + 3);
          end
          if (d < 0) begin
            d = 0;
          end
        end
      end else if (kind < 9) begin
        send_echo(ECHO_W'($urandom));
        sent++;
      end else begin
        send_distance((lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(0, 127));
        sent++;
      end
    end
    echo.valid <= 1'b0;
  endtask

  initial begin
    logic [ECHO_W-1:0] edge_widths[$];
    int ramp[$];
    edge_widths = '{16'd0, 16'hFFFF, 16'd580, 16'd637, 16'd638, 16'd5800, 16'd5857, 16'd5858};
    ramp = '{95, 88, 81, 74, 67, 60, 60, 53, 46, 39, 32, 25, 18};
    cfg.valid <= 1'b0;
    cfg.index <= '0;
    cfg.data <= '0;
    echo.valid <= 1'b0;
    echo.echo_width_us <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (edge_widths[k]) send_echo(edge_widths[k]);
    foreach (ramp[k]) send_distance(ramp[k]);
    echo.valid <= 1'b0;

    run_phase(90, 127, 0, 0, 0, 1'b1, 1'b0);
    run_phase(90, 100, 10, 5, 1, 1'b0, 1'b1);
    run_phase(30, 0, 127, 9, 15, 1'b1, 1'b0);
    run_phase(90, 127, 20, 15, 0, 1'b1, 1'b0);
    run_phase(90, 60, 5, 9, 15, 1'b1, 1'b0);
    run_phase(50, 90, 12, 3, 2, 1'b1, 1'b0);
    run_phase(90, $urandom_range(40, 127), $urandom_range(0, 30), $urandom_range(0, 9),
              $urandom_range(0, 4), 1'b1, 1'b0);

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (HISTORY_DEPTH_DEF + 8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
